>>> rtl/ils_pkg.sv
`default_nettype none
package ils_pkg;

	localparam int CAPACITY = 64;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;
	// wide enough for both the position field and the entry count
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_GET    = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage
`default_nettype wire

>>> rtl/ils_if.sv
`default_nettype none
interface ils_cmd_if import ils_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink (input valid, cmd, position, value, output ready);
endinterface

interface ils_res_if import ils_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [STAT_W-1:0]        status;
	logic [LEN_W-1:0]         length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink (input valid, read_value, status, length, output ready);
endinterface
`default_nettype wire

>>> rtl/indexed_list_store_core.sv
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit words, edited by position.
// Each command item (insert, get, delete) yields exactly one result item
// carrying the word read (get only, else 0), a status (ok, position out of
// range, store full) and the list length after the command. Entries live in
// a single-port-write, registered-read RAM; insert and delete move the later
// entries one at a time through that RAM, each moved entry read and then
// written, with one shared up/down cursor stepping the address. A rejected
// command goes straight to its result without moving any entry, and a result
// can wait for the sink to take the previous one. The command port is ready
// only while no command is in flight and is ready again in the cycle the
// result turns valid. A finished result sits in an output register, so the
// next command is taken while that result still waits for the sink. No
// clearing pass is needed after reset: only entries below the length are
// ever used.
module indexed_list_store_core import ils_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ils_cmd_if.sink    req,
	ils_res_if.source  rsp
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_UP_RD = 7'b0000010,
		S_UP_WR = 7'b0000100,
		S_DN_RD = 7'b0001000,
		S_DN_WR = 7'b0010000,
		S_GET   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  count_q;   // entries held
	logic [CNT_W-1:0]  cur_q;     // cursor walking the shifted entries
	logic [CNT_W-1:0]  pos_q;     // target position of the command in flight
	logic [DATA_W-1:0] val_q;     // word to insert

	// result of the command in flight
	logic [DATA_W-1:0] res_rd_q;
	status_t           res_st_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_rd_q;
	logic [STAT_W-1:0] out_st_q;
	logic [LEN_W-1:0]  out_len_q;

	// RAM port
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;

	logic [CMP_W-1:0]  pos_cmp;
	logic [CMP_W-1:0]  cnt_cmp;
	logic              step_dn;
	logic [CNT_W-1:0]  step_sum;
	logic              out_free;

	// decode of the command on offer
	status_t           acc_st;
	state_t            acc_state;

	ils_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign pos_cmp = CMP_W'(req.position);
	assign cnt_cmp = CMP_W'(count_q);

	// The one shared step unit: cursor plus one (delete walks up) or minus
	// one (insert walks down).
	assign step_dn  = (state_q == S_DN_RD) || (state_q == S_DN_WR);
	assign step_sum = cur_q + (step_dn ? CNT_W'(1) : {CNT_W{1'b1}});

	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.status     = out_st_q;
	assign rsp.length     = out_len_q;

	// Range and full checks on the offered command; the position check
	// wins over the full check.
	always_comb begin
		acc_st    = ST_RANGE;
		acc_state = S_DONE;
		case (req.cmd)
			CMD_INSERT: begin
				if (pos_cmp > cnt_cmp) begin
					acc_st = ST_RANGE;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					acc_st = ST_FULL;
				end else begin
					acc_st    = ST_OK;
					acc_state = S_UP_RD;
				end
			end
			CMD_GET: begin
				if (pos_cmp < cnt_cmp) begin
					acc_st    = ST_OK;
					acc_state = S_GET;
				end
			end
			CMD_DELETE: begin
				if (pos_cmp < cnt_cmp) begin
					acc_st    = ST_OK;
					acc_state = S_DN_RD;
				end
			end
			default: begin
				acc_st = ST_RANGE;
			end
		endcase
	end

	// RAM addressing per sequencer step
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q[ADDR_W-1:0];
		wr_data = rd_data;
		rd_addr = step_sum[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				// a get reads its entry straight away
				rd_addr = pos_cmp[ADDR_W-1:0];
			end
			S_UP_RD: begin
				if (cur_q == pos_q) begin
					// gap is open: drop the new word in
					wr_en   = 1'b1;
					wr_addr = pos_q[ADDR_W-1:0];
					wr_data = val_q;
				end
			end
			S_UP_WR, S_DN_WR: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			pos_q       <= '0;
			val_q       <= '0;
			res_rd_q    <= '0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_st_q    <= '0;
			out_len_q   <= '0;
		end else begin
			// load a finished result, else drop the one the sink takes
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_rd_q <= '0;
						res_st_q <= acc_st;
						state_q  <= acc_state;
						pos_q    <= pos_cmp[CNT_W-1:0];
						val_q    <= req.value;
						// insert walks down from the end, delete up from the position
						cur_q    <= (req.cmd == CMD_INSERT) ? count_q : pos_cmp[CNT_W-1:0];
					end
				end
				S_UP_RD: begin
					if (cur_q == pos_q) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					cur_q   <= step_sum;
					state_q <= S_UP_RD;
				end
				S_DN_RD: begin
					if (step_sum >= count_q) begin
						// last entry reached: shrink
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					cur_q   <= step_sum;
					state_q <= S_DN_RD;
				end
				S_GET: begin
					res_rd_q <= rd_data;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_rd_q    <= res_rd_q;
						out_st_q    <= res_st_q;
						out_len_q   <= LEN_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != S_IDLE) && (state_q != S_DONE))
		else $error("RAM write outside a shift step");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("command port ready right after an accept");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_st_q == ST_FULL)) |-> (out_len_q == LEN_W'(CAPACITY)))
		else $error("full status with length below capacity");

	a_get_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GET) |-> (count_q != '0))
		else $error("get issued on an empty list");

endmodule
`default_nettype wire

>>> rtl/ils_ram.sv
`default_nettype none
module ils_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire
